>>> hw/rtl/rpm_pkg.sv
package rpm_pkg;

	localparam int IDX_W = 32;
	localparam int VALUE_W = 64;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_NOT_FOUND = 2'd1;
	localparam status_t STATUS_POOL_FULL = 2'd2;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [IDX_W-1:0] LOWEST_RESET = 32'd1000000000;

endpackage

>>> hw/rtl/rpm_ram.sv
module rpm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/radix_page_map.sv
// Channel   Direction  Transfer condition     Signals
// command   in         start && !busy         command, index, write_value
// result    out        done (one cycle)       status, read_value, min_index, max_index
//
// A leaf-page cache hit goes through S_LEAF to the registered done; a table walk checks
// each upper-level pointer in S_WCHK, and a write adds an S_ALLOC step per allocated
// page. A missing path or a full pool ends the walk early; a read of a key cached as
// missing answers in the cycle after the transfer. The next command is taken while a
// result shows. After reset busy is high while all POOL_PAGES * 2^LEVEL_BITS words
// (16384 by default) are cleared, one word a cycle. The receiver cannot stall.
module radix_page_map #(
	parameter int LEVEL_BITS = 8,
	parameter int POOL_PAGES = 64,
	parameter int INDEX_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [rpm_pkg::IDX_W-1:0]     index,
	input  logic [rpm_pkg::VALUE_W-1:0]   write_value,
	output logic                          done,
	output rpm_pkg::status_t              status,
	output logic [rpm_pkg::VALUE_W-1:0]   read_value,
	output logic [rpm_pkg::IDX_W-1:0]     min_index,
	output logic [rpm_pkg::IDX_W-1:0]     max_index
);

	import rpm_pkg::*;

	localparam int LEVELS = (INDEX_BITS + LEVEL_BITS - 1) / LEVEL_BITS;
	localparam int PAGE_W = $clog2(POOL_PAGES);
	localparam int USED_W = $clog2(POOL_PAGES + 1);
	localparam int ADDR_W = PAGE_W + LEVEL_BITS;
	localparam int DEPTH = POOL_PAGES * (1 << LEVEL_BITS);
	localparam int LV_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int KEY_W = (INDEX_BITS > LEVEL_BITS) ? INDEX_BITS - LEVEL_BITS : 1;
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WCHK  = 2'd1;
	localparam logic [1:0] S_ALLOC = 2'd2;
	localparam logic [1:0] S_LEAF  = 2'd3;

	function automatic logic [LEVEL_BITS-1:0] slice_of(input logic [IDX_W-1:0] idx,
		input int lv);
		logic [IDX_W-1:0] sh;
		sh = idx >> ((LEVELS - 1 - lv) * LEVEL_BITS);
		return sh[LEVEL_BITS-1:0];
	endfunction

	logic [1:0]            state_q, state_d;
	logic [LV_W-1:0]       lv_q, lv_d;
	logic [PAGE_W-1:0]     page_q, page_d;
	logic [USED_W-1:0]     used_q, used_d;
	logic [KEY_W-1:0]      ckey_q, ckey_d;
	logic [PAGE_W-1:0]     cpage_q, cpage_d;
	logic                  cvalid_q, cvalid_d;
	logic [IDX_W-1:0]      lowest_q, lowest_d;
	logic [IDX_W-1:0]      highest_q, highest_d;
	logic                  clr_busy_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic                  done_q;
	status_t               status_q;
	logic [VALUE_W-1:0]    value_q;

	logic                  cmd_q;
	logic [IDX_W-1:0]      idx_q;
	logic [VALUE_W-1:0]    wv_q;

	logic                  accept;
	logic [IDX_W-1:0]      in_idx;
	logic [KEY_W-1:0]      in_key;
	logic [KEY_W-1:0]      key_q;
	logic [LEVEL_BITS-1:0] in_off;
	logic [LEVEL_BITS-1:0] off_q;
	logic                  start_walk;
	logic                  ptr_ok;
	logic [PAGE_W-1:0]     new_page;
	logic [PAGE_W-1:0]     fresh_page;
	logic                  finish;
	status_t               fin_status;
	logic [VALUE_W-1:0]    fin_value;

	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [VALUE_W-1:0]    rd_data;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [VALUE_W-1:0]    wr_data;

	rpm_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign busy   = clr_busy_q || (state_q != S_IDLE);
	assign accept = start && !busy;
	assign in_idx = index & IDX_MASK;
	assign in_key = KEY_W'(in_idx >> LEVEL_BITS);
	assign in_off = in_idx[LEVEL_BITS-1:0];
	assign key_q  = KEY_W'(idx_q >> LEVEL_BITS);
	assign off_q  = idx_q[LEVEL_BITS-1:0];

	assign ptr_ok     = (rd_data != '0) && (rd_data < VALUE_W'(POOL_PAGES));
	assign new_page   = rd_data[PAGE_W-1:0];
	assign fresh_page = PAGE_W'(used_q);

	always_comb begin
		state_d    = state_q;
		lv_d       = lv_q;
		page_d     = page_q;
		used_d     = used_q;
		ckey_d     = ckey_q;
		cpage_d    = cpage_q;
		cvalid_d   = cvalid_q;
		lowest_d   = lowest_q;
		highest_d  = highest_q;
		start_walk = 1'b0;
		finish     = 1'b0;
		fin_status = STATUS_OK;
		fin_value  = '0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = clr_addr_q;
		wr_data    = '0;

		if (clr_busy_q) begin
			wr_en = 1'b1;
		end

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command == CMD_READ) begin
						if (in_key == ckey_q) begin
							if (cvalid_q) begin
								rd_en   = 1'b1;
								rd_addr = {cpage_q, in_off};
								page_d  = cpage_q;
								state_d = S_LEAF;
							end else begin
								finish     = 1'b1;
								fin_status = STATUS_NOT_FOUND;
							end
						end else begin
							ckey_d     = in_key;
							cvalid_d   = 1'b0;
							start_walk = 1'b1;
						end
					end else begin
						if (in_key == ckey_q && cvalid_q) begin
							rd_en   = 1'b1;
							rd_addr = {cpage_q, in_off};
							page_d  = cpage_q;
							state_d = S_LEAF;
						end else begin
							start_walk = 1'b1;
						end
					end
					if (start_walk) begin
						lv_d   = '0;
						page_d = '0;
						rd_en  = 1'b1;
						if (LEVELS == 1) begin
							ckey_d   = in_key;
							cpage_d  = '0;
							cvalid_d = 1'b1;
							rd_addr  = {PAGE_W'(0), in_off};
							state_d  = S_LEAF;
						end else begin
							rd_addr = {PAGE_W'(0), slice_of(in_idx, 0)};
							state_d = S_WCHK;
						end
					end
				end
			end
			S_WCHK: begin
				if (ptr_ok) begin
					page_d = new_page;
					rd_en  = 1'b1;
					if (int'(lv_q) == LEVELS - 2) begin
						ckey_d   = key_q;
						cpage_d  = new_page;
						cvalid_d = 1'b1;
						rd_addr  = {new_page, off_q};
						state_d  = S_LEAF;
					end else begin
						lv_d    = LV_W'(lv_q + 1'b1);
						rd_addr = {new_page, slice_of(idx_q, int'(lv_q) + 1)};
					end
				end else if (cmd_q == CMD_READ) begin
					finish     = 1'b1;
					fin_status = STATUS_NOT_FOUND;
					state_d    = S_IDLE;
				end else if ((LEVELS - 1 - int'(lv_q)) > (POOL_PAGES - int'(used_q))) begin
					finish     = 1'b1;
					fin_status = STATUS_POOL_FULL;
					state_d    = S_IDLE;
				end else begin
					state_d = S_ALLOC;
				end
			end
			S_ALLOC: begin
				wr_en   = 1'b1;
				wr_addr = {page_q, slice_of(idx_q, int'(lv_q))};
				wr_data = VALUE_W'(used_q);
				page_d  = fresh_page;
				used_d  = USED_W'(used_q + 1'b1);
				if (int'(lv_q) == LEVELS - 2) begin
					ckey_d   = key_q;
					cpage_d  = fresh_page;
					cvalid_d = 1'b1;
					rd_en    = 1'b1;
					rd_addr  = {fresh_page, off_q};
					state_d  = S_LEAF;
				end else begin
					lv_d = LV_W'(lv_q + 1'b1);
				end
			end
			S_LEAF: begin
				if (cmd_q == CMD_WRITE) begin
					wr_en   = 1'b1;
					wr_addr = {page_q, off_q};
					wr_data = wv_q;
					if (lowest_q > idx_q) begin
						lowest_d = idx_q;
					end
					if (highest_q < idx_q) begin
						highest_d = idx_q;
					end
				end
				finish     = 1'b1;
				fin_status = STATUS_OK;
				fin_value  = rd_data;
				state_d    = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lv_q       <= '0;
			page_q     <= '0;
			used_q     <= USED_W'(1);
			ckey_q     <= '0;
			cpage_q    <= '0;
			cvalid_q   <= 1'b0;
			lowest_q   <= LOWEST_RESET;
			highest_q  <= '0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			lv_q      <= lv_d;
			page_q    <= page_d;
			used_q    <= used_d;
			ckey_q    <= ckey_d;
			cpage_q   <= cpage_d;
			cvalid_q  <= cvalid_d;
			lowest_q  <= lowest_d;
			highest_q <= highest_d;
			done_q    <= finish;
			if (clr_busy_q) begin
				clr_addr_q <= ADDR_W'(clr_addr_q + 1'b1);
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			idx_q <= in_idx;
			wv_q  <= write_value;
		end
		if (finish) begin
			status_q <= fin_status;
			value_q  <= fin_value;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = value_q;
	assign min_index  = lowest_q;
	assign max_index  = highest_q;

`ifndef SYNTHESIS
	a_cache_page_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		cvalid_q |-> (int'(cpage_q) < int'(used_q)))
		else $error("cached leaf page lies outside the allocated pool");

	a_pool_full_no_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STATUS_POOL_FULL) |-> $stable(used_q))
		else $error("pages were allocated by a write that reported pool_full");

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !done_q)
		else $error("result transfer during the memory clearing pass");
`endif

endmodule
